[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the RGB to HSV converter RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is held
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

[rtl/core/hsv_pkg.sv]
// ---------------------------------------------------------------------------
// hsv_pkg
// Shared types and constants of the RGB to HSV converter.
// ---------------------------------------------------------------------------
package hsv_pkg;

  // Field widths
  localparam int PIX_W = 8;
  localparam int HUE_W = 15;
  localparam int SAT_W = 13;
  localparam int VAL_W = 8;

  // Stream widths (whole bytes)
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 40;

  // Parameter defaults
  localparam int HUE_FRAC_BITS_DEF = 6;
  localparam int SAT_FRAC_BITS_DEF = 12;

  // Quotient bits resolved per divider pipeline stage
  localparam int DIV_STEPS = 4;

  // Sector of the largest channel
  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  // Per-item sideband carried along the divider pipeline
  typedef struct packed {
    logic [PIX_W-1:0] value;   // largest channel, also saturation divisor
    logic [PIX_W-1:0] delta;   // max - min, hue divisor
    sector_t          sector;
    logic             neg;     // hue offset inside the sector is negative
    logic             grey;    // max equals min
  } side_t;

endpackage

[rtl/core/hsv_front.sv]
// ---------------------------------------------------------------------------
// hsv_front
// Max/min search, sector pick and divider numerator setup for one pixel.
// ---------------------------------------------------------------------------
module hsv_front #(
  parameter int HUE_FRAC_BITS = hsv_pkg::HUE_FRAC_BITS_DEF,
  parameter int SAT_FRAC_BITS = hsv_pkg::SAT_FRAC_BITS_DEF,
  parameter int QW            = 13
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [hsv_pkg::PIX_W-1:0] red,
  input  logic [hsv_pkg::PIX_W-1:0] green,
  input  logic [hsv_pkg::PIX_W-1:0] blue,
  output logic                     out_valid,
  input  logic                     out_ready,
  output hsv_pkg::side_t           out_side,
  output logic [hsv_pkg::PIX_W-1:0] out_rem_h,
  output logic [QW-1:0]            out_work_h,
  output logic [hsv_pkg::PIX_W-1:0] out_rem_s,
  output logic [QW-1:0]            out_work_s
);

  localparam int NW = QW + hsv_pkg::PIX_W;

  logic [hsv_pkg::PIX_W-1:0] mx, mn;
  logic signed [hsv_pkg::PIX_W:0] offs;
  logic [hsv_pkg::PIX_W-1:0] mag;
  logic [NW-1:0] num_h, num_s;
  hsv_pkg::side_t side_next;

  assign in_ready = !out_valid || out_ready;

  // Largest and smallest channel, sector by priority red, green, blue
  always_comb begin
    mx = (red >= green) ? red : green;
    mx = (mx >= blue) ? mx : blue;
    mn = (red <= green) ? red : green;
    mn = (mn <= blue) ? mn : blue;
    side_next.value = mx;
    side_next.delta = mx - mn;
    side_next.grey  = (mx == mn);
    if (red >= mx) begin
      side_next.sector = hsv_pkg::SECT_RED;
      offs = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (green >= mx) begin
      side_next.sector = hsv_pkg::SECT_GREEN;
      offs = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      side_next.sector = hsv_pkg::SECT_BLUE;
      offs = $signed({1'b0, red}) - $signed({1'b0, green});
    end
    side_next.neg = offs[hsv_pkg::PIX_W];
    mag = side_next.neg ? hsv_pkg::PIX_W'(-offs) : offs[hsv_pkg::PIX_W-1:0];
  end

  // Numerators: |offset| * 60 * 2^H and delta * 2^S
  assign num_h = ((NW'(mag) << 6) - (NW'(mag) << 2)) << HUE_FRAC_BITS;
  assign num_s = NW'(side_next.delta) << SAT_FRAC_BITS;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      out_side   <= side_next;
      out_rem_h  <= num_h[NW-1:QW];
      out_work_h <= num_h[QW-1:0];
      out_rem_s  <= num_s[NW-1:QW];
      out_work_s <= num_s[QW-1:0];
    end
  end

  `include "assert_macros.svh"

  // Initial partial remainders must already be below their divisors
  `ASSERT_CLK(a_front_rem, out_valid && !out_side.grey |-> out_rem_h < out_side.delta && out_rem_s < out_side.value)

endmodule

[rtl/core/hsv_div_stage.sv]
// ---------------------------------------------------------------------------
// hsv_div_stage
// One pipeline stage of the two restoring dividers (hue and saturation).
// ---------------------------------------------------------------------------
module hsv_div_stage #(
  parameter int QW    = 13,
  parameter int STEPS = hsv_pkg::DIV_STEPS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  hsv_pkg::side_t            in_side,
  input  logic [hsv_pkg::PIX_W-1:0] in_rem_h,
  input  logic [QW-1:0]             in_work_h,
  input  logic [hsv_pkg::PIX_W-1:0] in_rem_s,
  input  logic [QW-1:0]             in_work_s,
  output logic                      out_valid,
  input  logic                      out_ready,
  output hsv_pkg::side_t            out_side,
  output logic [hsv_pkg::PIX_W-1:0] out_rem_h,
  output logic [QW-1:0]             out_work_h,
  output logic [hsv_pkg::PIX_W-1:0] out_rem_s,
  output logic [QW-1:0]             out_work_s
);

  logic [hsv_pkg::PIX_W-1:0] rem_h_next, rem_s_next;
  logic [QW-1:0]             work_h_next, work_s_next;
  logic [hsv_pkg::PIX_W:0]   part_h, part_s;

  assign in_ready = !out_valid || out_ready;

  // STEPS quotient bits: shift in a numerator bit, compare, subtract.
  // The work word shifts numerator bits out at the top, quotient bits in below.
  always_comb begin
    rem_h_next  = in_rem_h;
    work_h_next = in_work_h;
    rem_s_next  = in_rem_s;
    work_s_next = in_work_s;
    part_h      = '0;
    part_s      = '0;
    for (int i = 0; i < STEPS; i++) begin
      part_h = {rem_h_next, work_h_next[QW-1]};
      if (part_h >= {1'b0, in_side.delta}) begin
        rem_h_next  = hsv_pkg::PIX_W'(part_h - {1'b0, in_side.delta});
        work_h_next = {work_h_next[QW-2:0], 1'b1};
      end else begin
        rem_h_next  = part_h[hsv_pkg::PIX_W-1:0];
        work_h_next = {work_h_next[QW-2:0], 1'b0};
      end
      part_s = {rem_s_next, work_s_next[QW-1]};
      if (part_s >= {1'b0, in_side.value}) begin
        rem_s_next  = hsv_pkg::PIX_W'(part_s - {1'b0, in_side.value});
        work_s_next = {work_s_next[QW-2:0], 1'b1};
      end else begin
        rem_s_next  = part_s[hsv_pkg::PIX_W-1:0];
        work_s_next = {work_s_next[QW-2:0], 1'b0};
      end
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      out_side   <= in_side;
      out_rem_h  <= rem_h_next;
      out_work_h <= work_h_next;
      out_rem_s  <= rem_s_next;
      out_work_s <= work_s_next;
    end
  end

  `include "assert_macros.svh"

  // Restoring division keeps each remainder below its divisor
  `ASSERT_CLK(a_div_rem, out_valid && !out_side.grey |-> out_rem_h < out_side.delta && out_rem_s < out_side.value)
  // Synchronous reset empties the stage
  `ASSERT_ALWAYS(a_div_rst, $past(rst) |-> !out_valid)

endmodule

[rtl/core/hsv_back.sv]
// ---------------------------------------------------------------------------
// hsv_back
// Hue assembly from sector base and quotient, grey override, output register.
// ---------------------------------------------------------------------------
module hsv_back #(
  parameter int HUE_FRAC_BITS = hsv_pkg::HUE_FRAC_BITS_DEF,
  parameter int QW            = 13
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  hsv_pkg::side_t            in_side,
  input  logic [hsv_pkg::PIX_W-1:0] in_rem_h,
  input  logic [QW-1:0]             in_quo_h,
  input  logic [QW-1:0]             in_quo_s,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [hsv_pkg::HUE_W-1:0] hue,
  output logic [hsv_pkg::SAT_W-1:0] saturation,
  output logic [hsv_pkg::VAL_W-1:0] value
);

  // Hue before masking spans up to 360 * 2^H
  localparam int HCW = 10 + HUE_FRAC_BITS;
  localparam logic [HCW-1:0] TURN2 = HCW'(120) << HUE_FRAC_BITS;
  localparam logic [HCW-1:0] TURN4 = HCW'(240) << HUE_FRAC_BITS;
  localparam logic [HCW-1:0] TURN6 = HCW'(360) << HUE_FRAC_BITS;

  logic [HCW-1:0] base;
  logic [HCW-1:0] hue_full;
  logic [hsv_pkg::HUE_W-1:0] hue_next;
  logic [hsv_pkg::SAT_W-1:0] sat_next;

  assign in_ready = !out_valid || out_ready;

  // Sector base; a negative red offset wraps from the full turn
  always_comb begin
    case (in_side.sector)
      hsv_pkg::SECT_RED:   base = in_side.neg ? TURN6 : '0;
      hsv_pkg::SECT_GREEN: base = TURN2;
      hsv_pkg::SECT_BLUE:  base = TURN4;
      default:             base = '0;
    endcase
  end

  // Negative offset: floor of a negative fraction is minus the ceiling
  always_comb begin
    if (in_side.neg) begin
      hue_full = base - HCW'(in_quo_h) - HCW'(in_rem_h != '0);
    end else begin
      hue_full = base + HCW'(in_quo_h);
    end
    if (in_side.grey) begin
      hue_next = '0;
      sat_next = '0;
    end else begin
      hue_next = hsv_pkg::HUE_W'(hue_full);
      sat_next = hsv_pkg::SAT_W'(in_quo_s);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      hue        <= hue_next;
      saturation <= sat_next;
      value      <= in_side.value;
    end
  end

  `include "assert_macros.svh"

  // Black is grey: no hue, no saturation
  `ASSERT_CLK(a_back_black, out_valid && value == '0 |-> hue == '0 && saturation == '0)

endmodule

[rtl/core/rgb_to_hsv_converter.sv]
// ---------------------------------------------------------------------------
// rgb_to_hsv_converter
// Registers: front, one divider stage per four quotient bits of QW, output;
// QW = max(SAT_FRAC_BITS + 1, HUE_FRAC_BITS + 6). Throughput: one item per cycle,
// set by the four-quotient-bit divider stages, unless m_tready stalls the output.
// Reset: synchronous, active high; empties every stage, no other state.
// ---------------------------------------------------------------------------
module rgb_to_hsv_converter #(
  parameter int HUE_FRAC_BITS = hsv_pkg::HUE_FRAC_BITS_DEF,
  parameter int SAT_FRAC_BITS = hsv_pkg::SAT_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [hsv_pkg::S_TDATA_W-1:0] s_tdata,   // red, green, blue
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [hsv_pkg::M_TDATA_W-1:0] m_tdata    // hue, saturation, value, zero pad
);

  localparam int QW  = (SAT_FRAC_BITS + 1 > HUE_FRAC_BITS + 6) ?
                       SAT_FRAC_BITS + 1 : HUE_FRAC_BITS + 6;
  localparam int NST = (QW + hsv_pkg::DIV_STEPS - 1) / hsv_pkg::DIV_STEPS;
  localparam int PAD = hsv_pkg::M_TDATA_W - hsv_pkg::HUE_W - hsv_pkg::SAT_W
                       - hsv_pkg::VAL_W;

  logic                      vld   [0:NST];
  logic                      rdy   [0:NST];
  hsv_pkg::side_t            side  [0:NST];
  logic [hsv_pkg::PIX_W-1:0] rem_h [0:NST];
  logic [QW-1:0]             work_h[0:NST];
  logic [hsv_pkg::PIX_W-1:0] rem_s [0:NST];
  logic [QW-1:0]             work_s[0:NST];

  logic [hsv_pkg::HUE_W-1:0] hue;
  logic [hsv_pkg::SAT_W-1:0] saturation;
  logic [hsv_pkg::VAL_W-1:0] value;

  // Channel compare and numerator setup
  hsv_front #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS),
    .SAT_FRAC_BITS(SAT_FRAC_BITS),
    .QW           (QW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .red       (s_tdata[7:0]),
    .green     (s_tdata[15:8]),
    .blue      (s_tdata[23:16]),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_side  (side[0]),
    .out_rem_h (rem_h[0]),
    .out_work_h(work_h[0]),
    .out_rem_s (rem_s[0]),
    .out_work_s(work_s[0])
  );

  // Divider pipeline, last stage takes whatever bits remain
  for (genvar i = 0; i < NST; i++) begin : g_div
    localparam int STEPS = (QW - hsv_pkg::DIV_STEPS * i > hsv_pkg::DIV_STEPS) ?
                           hsv_pkg::DIV_STEPS : QW - hsv_pkg::DIV_STEPS * i;
    hsv_div_stage #(
      .QW   (QW),
      .STEPS(STEPS)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[i]),
      .in_ready  (rdy[i]),
      .in_side   (side[i]),
      .in_rem_h  (rem_h[i]),
      .in_work_h (work_h[i]),
      .in_rem_s  (rem_s[i]),
      .in_work_s (work_s[i]),
      .out_valid (vld[i+1]),
      .out_ready (rdy[i+1]),
      .out_side  (side[i+1]),
      .out_rem_h (rem_h[i+1]),
      .out_work_h(work_h[i+1]),
      .out_rem_s (rem_s[i+1]),
      .out_work_s(work_s[i+1])
    );
  end

  // Hue assembly and output register
  hsv_back #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS),
    .QW           (QW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[NST]),
    .in_ready  (rdy[NST]),
    .in_side   (side[NST]),
    .in_rem_h  (rem_h[NST]),
    .in_quo_h  (work_h[NST]),
    .in_quo_s  (work_s[NST]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .hue       (hue),
    .saturation(saturation),
    .value     (value)
  );

  assign m_tdata = {{PAD{1'b0}}, value, saturation, hue};

endmodule
